// ----- rtl/srea_pkg.sv -----
// ----------------------------------------------------------------------------
// Spike rate encoder array package
// Shared widths, constants, codes and types of the rate encoder array.
// ----------------------------------------------------------------------------
`default_nettype none

package srea_pkg;

    // Field widths
    localparam int unsigned IDX_W = 10;
    localparam int unsigned CUR_W = 17;
    localparam int unsigned INC_W = 17;
    localparam int unsigned MEM_W = 20;
    localparam int unsigned THR_W = 18;

    // Fixed point constants
    localparam logic [CUR_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [THR_W-1:0] THR_RESET  = 18'd65536;
    localparam logic [MEM_W:0]   MEM_MAX_X  = 21'd524287;
    localparam logic [MEM_W:0]   ONE_Q16_X  = 21'd65536;

    // Latency of the current warp pipeline in cycles
    localparam int unsigned WARP_LAT = 3;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned FIFO_CW    = 4;

    // Item operation codes
    typedef enum logic
    {
        FUNC_SET  = 1'b0,
        FUNC_STEP = 1'b1
    } func_t;

    // Control that travels with an item down the pipeline
    typedef struct packed
    {
        logic             valid;
        func_t            func;
        logic [IDX_W-1:0] idx;
    } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/srea_warp.sv -----
// ----------------------------------------------------------------------------
// Current warp pipeline
// Saturates a Q0.16 current to 1.0 and maps it through the cubic
// 3x^3 - 4.5x^2 + 2.5x, rounded to nearest, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module srea_warp
(
    input  wire logic                         clk,
    input  wire logic [srea_pkg::CUR_W-1:0]   cur,
    output logic      [srea_pkg::INC_W-1:0]   inc
);

    logic [srea_pkg::CUR_W-1:0] x_sat;
    logic [srea_pkg::CUR_W-1:0] x1_reg;
    logic [33:0]                sq1_reg;
    logic [srea_pkg::CUR_W-1:0] x2_reg;
    logic [34:0]                t2_reg;
    logic [51:0]                prod3_reg;
    logic [36:0]                t_sum;
    logic [52:0]                rnd;
    logic [19:0]                r;

    // Saturate the current to 1.0.
    assign x_sat = (cur > srea_pkg::ONE_Q16) ? srea_pkg::ONE_Q16 : cur;

    // The polynomial is evaluated as x * (6x^2 - 9x*2^16 + 5*2^32); the inner
    // term is always positive since the quadratic has no real roots.
    assign t_sum = ({3'b000, sq1_reg} * 37'd6) + (37'd5 << 32)
                 - (({20'd0, x1_reg} * 37'd9) << 16);

    // Stage 1 squares, stage 2 forms the inner term, stage 3 multiplies by x.
    always_ff @(posedge clk)
    begin
        x1_reg    <= x_sat;
        sq1_reg   <= 34'(x_sat) * 34'(x_sat);
        x2_reg    <= x1_reg;
        t2_reg    <= t_sum[34:0];
        prod3_reg <= 52'(x2_reg) * 52'(t2_reg);
    end

    // Round to nearest with ties up, scale back to Q0.16 and clamp at 1.0.
    assign rnd = {1'b0, prod3_reg} + (53'd1 << 32);
    assign r   = rnd[52:33];
    assign inc = (r > 20'd65536) ? srea_pkg::ONE_Q16 : r[srea_pkg::INC_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/spike_rate_encoder_array_unit.sv -----
// ----------------------------------------------------------------------------
// Spike rate encoder array
// Integrate-and-fire rate encoders, one per neuron, kept in two memories.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one item per beat: tuser selects set (0) or
// step (1), tdata holds the neuron index and the Q0.16 current. A set beat
// stores the warped current as the neuron's increment; a step beat adds the
// increment to the membrane value and returns one output beat with the spike
// flag and the neuron index. Set beats and beats addressing a neuron at or
// beyond NEURONS return nothing.
// Throughput is one beat per cycle while s_axis_tready is high. A step beat
// passes through the three warp stages, a stage that reads the memories and
// a stage that writes back and queues the result for the output stream.
// Back-to-back accesses to the same neuron are forwarded from the write stage.
// After reset a clearing pass zeroes both memories, one entry per cycle, over
// all NEURONS entries; input tready stays low during that pass.
// Results go through an eight entry queue. When the receiver stalls, input
// beats are still taken until eight beats are queued or in flight.
// The threshold register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_rate_encoder_array_unit
#(
    parameter int unsigned NEURONS = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // neuron_index[9:0], current_in[26:10]
    input  wire logic [0:0]  s_axis_tuser,   // func[0]
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // spike[0], spike_index[10:1]
    // Threshold register write
    input  wire logic        cfg_we,
    input  wire logic [17:0] cfg_wdata
);

    localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam logic [16:0] NEURONS_X = 17'(NEURONS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);

    typedef logic [srea_pkg::IDX_W:0] fifo_entry_t;

    // Memories
    logic [srea_pkg::INC_W-1:0] inc_mem [NEURONS];
    logic [srea_pkg::MEM_W-1:0] mbr_mem [NEURONS];

    // Registers
    logic [srea_pkg::THR_W-1:0] thr_reg;
    logic                       clr_reg;
    logic [AW-1:0]              clr_cnt_reg;
    srea_pkg::ctl_t             ctl_reg [srea_pkg::WARP_LAT];
    srea_pkg::ctl_t             s4_ctl_reg;
    logic [srea_pkg::INC_W-1:0] s4_inc_reg;
    logic [srea_pkg::INC_W-1:0] rd_inc_reg;
    logic [srea_pkg::MEM_W-1:0] rd_mbr_reg;
    logic                       fw_valid_reg;
    logic                       fw_set_reg;
    logic [AW-1:0]              fw_addr_reg;
    logic [srea_pkg::MEM_W-1:0] fw_data_reg;
    logic [srea_pkg::FIFO_CW-1:0] pend_reg;
    logic [srea_pkg::FIFO_CW-1:0] pend_next;
    logic [srea_pkg::FIFO_CW-1:0] cnt_reg;
    logic [srea_pkg::FIFO_AW-1:0] head_reg;
    logic [srea_pkg::FIFO_AW-1:0] tail_reg;
    fifo_entry_t                  fifo_reg [srea_pkg::FIFO_DEPTH];

    // Input and stage signals
    logic [srea_pkg::IDX_W-1:0] in_idx;
    logic [srea_pkg::CUR_W-1:0] in_cur;
    srea_pkg::func_t            in_func;
    logic                       in_ok;
    logic                       accept;
    logic                       ins;
    logic [srea_pkg::INC_W-1:0] warp_inc;
    logic [AW-1:0]              addr3;
    logic [AW-1:0]              addr4;
    logic                       fw_hit;
    logic [srea_pkg::INC_W-1:0] inc_cur;
    logic [srea_pkg::MEM_W-1:0] mbr_cur;
    logic [srea_pkg::MEM_W:0]   sum;
    logic [srea_pkg::MEM_W:0]   sat;
    logic                       fired;
    logic [srea_pkg::MEM_W:0]   mbr_x;
    logic [srea_pkg::MEM_W-1:0] mbr_new;
    logic                       s4_set;
    logic                       s4_step;
    logic                       push;
    logic                       pop;
    logic                       drop;

    // Input beat unpacking
    assign in_idx  = s_axis_tdata[9:0];
    assign in_cur  = s_axis_tdata[26:10];
    assign in_func = srea_pkg::func_t'(s_axis_tuser[0]);
    assign in_ok   = {7'd0, in_idx} < NEURONS_X;

    assign s_axis_tready = !clr_reg && (pend_reg < srea_pkg::FIFO_CW'(srea_pkg::FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ins           = accept && in_ok;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= srea_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Clearing pass over both memories after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clr_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // Current warp runs alongside the control line.
    srea_warp u_warp
    (
        .clk (clk),
        .cur (in_cur),
        .inc (warp_inc)
    );

    // Control line matching the warp latency.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < srea_pkg::WARP_LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
            s4_ctl_reg <= '0;
        end
        else
        begin
            ctl_reg[0] <= '{valid: ins, func: in_func, idx: in_idx};
            for (int i = 1; i < srea_pkg::WARP_LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            s4_ctl_reg <= ctl_reg[srea_pkg::WARP_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        s4_inc_reg <= warp_inc;
    end

    assign addr3 = AW'(ctl_reg[srea_pkg::WARP_LAT-1].idx);
    assign addr4 = AW'(s4_ctl_reg.idx);

    // Memory read for the item leaving the warp pipeline.
    always_ff @(posedge clk)
    begin
        rd_inc_reg <= inc_mem[addr3];
        rd_mbr_reg <= mbr_mem[addr3];
    end

    // Forward the previous cycle's write when it hits the same neuron.
    assign fw_hit  = fw_valid_reg && (fw_addr_reg == addr4);
    assign inc_cur = (fw_hit && fw_set_reg) ? fw_data_reg[srea_pkg::INC_W-1:0] : rd_inc_reg;
    assign mbr_cur = (fw_hit && !fw_set_reg) ? fw_data_reg : rd_mbr_reg;

    // Integrate, saturate, compare and fire.
    assign sum     = {mbr_cur[srea_pkg::MEM_W-1], mbr_cur} + {4'd0, inc_cur};
    assign sat     = ($signed(sum) > $signed(srea_pkg::MEM_MAX_X)) ? srea_pkg::MEM_MAX_X : sum;
    assign fired   = $signed(sat) > $signed({3'd0, thr_reg});
    assign mbr_x   = fired ? (sat - srea_pkg::ONE_Q16_X) : sat;
    assign mbr_new = mbr_x[srea_pkg::MEM_W-1:0];

    assign s4_set  = s4_ctl_reg.valid && (s4_ctl_reg.func == srea_pkg::FUNC_SET);
    assign s4_step = s4_ctl_reg.valid && (s4_ctl_reg.func == srea_pkg::FUNC_STEP);

    // Memory write port, shared with the clearing pass.
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            inc_mem[clr_cnt_reg] <= '0;
            mbr_mem[clr_cnt_reg] <= '0;
        end
        else if (s4_set)
        begin
            inc_mem[addr4] <= s4_inc_reg;
        end
        else if (s4_step)
        begin
            mbr_mem[addr4] <= mbr_new;
        end
    end

    // Record of the last write for forwarding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            fw_valid_reg <= s4_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fw_set_reg  <= s4_set;
        fw_addr_reg <= addr4;
        fw_data_reg <= s4_set ? {3'd0, s4_inc_reg} : mbr_new;
    end

    // Result queue and the count of items that may still need a slot.
    assign push = s4_step;
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign drop = s4_set;

    assign pend_next = pend_reg + srea_pkg::FIFO_CW'(ins)
                     - srea_pkg::FIFO_CW'(drop) - srea_pkg::FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_reg + srea_pkg::FIFO_CW'(push) - srea_pkg::FIFO_CW'(pop);
            if (push)
            begin
                tail_reg <= tail_reg + srea_pkg::FIFO_AW'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + srea_pkg::FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[tail_reg] <= {s4_ctl_reg.idx, fired};
        end
    end

    // Output beat
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = {5'd0, fifo_reg[head_reg]};

endmodule

`default_nettype wire
